// ===== hw/rtl/triangle_plane_slice_assert.svh =====
// ----------------------------------------------------------------------------
// triangle plane slice assertion macros
// concurrent checks clocked on clock, masked while reset is high
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_SLICE_ASSERT_SVH
`define TRIANGLE_PLANE_SLICE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, sizes and helper functions of the triangle plane slice
// ----------------------------------------------------------------------------
package tps_pkg;

   // coordinates are two's complement fixed point; the binary point
   // position does not enter the arithmetic
   localparam int COORD_BITS  = 32;
   localparam int LANES       = 4;
   localparam int DIV_STAGES  = COORD_BITS;
   // input, setup, product, then one stage per quotient bit
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   localparam int LANE_X1 = 0;
   localparam int LANE_Y1 = 1;
   localparam int LANE_X2 = 2;
   localparam int LANE_Y2 = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        mag_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      vertex_type c;
      coord_type  h;
   } facet_type;

   typedef struct packed {
      coord_type base;
      logic      neg;
      mag_type   span;
      mag_type   num;
      mag_type   den;
   } setup_lane_type;

   typedef struct packed {
      logic                            hit;
      setup_lane_type [LANES-1:0]      lane;
   } setup_type;

   typedef struct packed {
      coord_type base;
      logic      neg;
      mag_type   den;
      mag_type   rem;
      mag_type   quo;
   } div_lane_type;

   typedef struct packed {
      logic                    hit;
      div_lane_type [LANES-1:0] lane;
   } div_type;

   function automatic logic crosses(coord_type pz, coord_type qz, coord_type h);
      return ((pz > h) && (qz < h)) || ((pz < h) && (qz > h));
   endfunction

   // |q - p|, always fits the coordinate width unsigned
   function automatic mag_type abs_diff(coord_type p, coord_type q);
      logic signed [COORD_BITS:0] d;
      logic signed [COORD_BITS:0] nd;
      d  = {q[COORD_BITS-1], q} - {p[COORD_BITS-1], p};
      nd = -d;
      return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

   function automatic setup_lane_type edge_lane(coord_type p, coord_type q,
                                               coord_type pz, coord_type qz,
                                               coord_type h);
      setup_lane_type l;
      l.base = p;
      l.neg  = (q < p);
      l.span = abs_diff(p, q);
      l.num  = abs_diff(pz, h);
      l.den  = abs_diff(pz, qz);
      return l;
   endfunction

   // zero offset: product 0 over divisor 1
   function automatic setup_lane_type vertex_lane(coord_type v);
      setup_lane_type l;
      l.base = v;
      l.neg  = 1'b0;
      l.span = '0;
      l.num  = '0;
      l.den  = mag_type'(1);
      return l;
   endfunction

endpackage

// ===== hw/rtl/tps_setup.sv =====
// ----------------------------------------------------------------------------
// tps_setup
// straddle test, edge choice and interpolation operands, registered
// ----------------------------------------------------------------------------
module tps_setup (
   input  logic                clock,
   input  logic                load,
   input  tps_pkg::facet_type  facet_d,
   output tps_pkg::setup_type  setup_ff
);
   import tps_pkg::*;

   logic      ab;
   logic      bc;
   logic      ca;
   logic      above;
   logic      below;
   setup_type setup_in;

   always_comb begin
      ab    = crosses(facet_d.a.z, facet_d.b.z, facet_d.h);
      bc    = crosses(facet_d.b.z, facet_d.c.z, facet_d.h);
      ca    = crosses(facet_d.c.z, facet_d.a.z, facet_d.h);
      above = (facet_d.a.z > facet_d.h) || (facet_d.b.z > facet_d.h) ||
              (facet_d.c.z > facet_d.h);
      below = (facet_d.a.z < facet_d.h) || (facet_d.b.z < facet_d.h) ||
              (facet_d.c.z < facet_d.h);
      setup_in.hit = above && below;
      setup_in.lane[LANE_X1] = vertex_lane('0);
      setup_in.lane[LANE_Y1] = vertex_lane('0);
      setup_in.lane[LANE_X2] = vertex_lane('0);
      setup_in.lane[LANE_Y2] = vertex_lane('0);
      if (setup_in.hit) begin
         if (ab) begin
            setup_in.lane[LANE_X1] = edge_lane(facet_d.a.x, facet_d.b.x,
                                               facet_d.a.z, facet_d.b.z, facet_d.h);
            setup_in.lane[LANE_Y1] = edge_lane(facet_d.a.y, facet_d.b.y,
                                               facet_d.a.z, facet_d.b.z, facet_d.h);
            if (bc) begin
               setup_in.lane[LANE_X2] = edge_lane(facet_d.b.x, facet_d.c.x,
                                                  facet_d.b.z, facet_d.c.z, facet_d.h);
               setup_in.lane[LANE_Y2] = edge_lane(facet_d.b.y, facet_d.c.y,
                                                  facet_d.b.z, facet_d.c.z, facet_d.h);
            end else if (ca) begin
               setup_in.lane[LANE_X2] = edge_lane(facet_d.c.x, facet_d.a.x,
                                                  facet_d.c.z, facet_d.a.z, facet_d.h);
               setup_in.lane[LANE_Y2] = edge_lane(facet_d.c.y, facet_d.a.y,
                                                  facet_d.c.z, facet_d.a.z, facet_d.h);
            end else begin
               setup_in.lane[LANE_X2] = vertex_lane(facet_d.c.x);
               setup_in.lane[LANE_Y2] = vertex_lane(facet_d.c.y);
            end
         end else begin
            if (bc) begin
               setup_in.lane[LANE_X1] = edge_lane(facet_d.b.x, facet_d.c.x,
                                                  facet_d.b.z, facet_d.c.z, facet_d.h);
               setup_in.lane[LANE_Y1] = edge_lane(facet_d.b.y, facet_d.c.y,
                                                  facet_d.b.z, facet_d.c.z, facet_d.h);
            end else begin
               setup_in.lane[LANE_X1] = vertex_lane(facet_d.b.x);
               setup_in.lane[LANE_Y1] = vertex_lane(facet_d.b.y);
            end
            if (ca) begin
               setup_in.lane[LANE_X2] = edge_lane(facet_d.c.x, facet_d.a.x,
                                                  facet_d.c.z, facet_d.a.z, facet_d.h);
               setup_in.lane[LANE_Y2] = edge_lane(facet_d.c.y, facet_d.a.y,
                                                  facet_d.c.z, facet_d.a.z, facet_d.h);
            end else begin
               setup_in.lane[LANE_X2] = vertex_lane(facet_d.a.x);
               setup_in.lane[LANE_Y2] = vertex_lane(facet_d.a.y);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         setup_ff <= setup_in;
      end
   end

endmodule

// ===== hw/rtl/tps_mul.sv =====
// ----------------------------------------------------------------------------
// tps_mul
// product of edge span and height offset per lane, registered
// ----------------------------------------------------------------------------
module tps_mul (
   input  logic                clock,
   input  logic                load,
   input  tps_pkg::setup_type  setup_d,
   output tps_pkg::div_type    div_ff
);
   import tps_pkg::*;

   logic [2*COORD_BITS-1:0] prod [LANES];
   div_type                 div_in;

   always_comb begin
      div_in.hit = setup_d.hit;
      for (int i = 0; i < LANES; i++) begin
         prod[i] = (2*COORD_BITS)'(setup_d.lane[i].span) *
                   (2*COORD_BITS)'(setup_d.lane[i].num);
         div_in.lane[i].base = setup_d.lane[i].base;
         div_in.lane[i].neg  = setup_d.lane[i].neg;
         div_in.lane[i].den  = setup_d.lane[i].den;
         // upper half is already below the divisor since num < den
         div_in.lane[i].rem  = prod[i][2*COORD_BITS-1:COORD_BITS];
         div_in.lane[i].quo  = prod[i][COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         div_ff <= div_in;
      end
   end

endmodule

// ===== hw/rtl/tps_div_stage.sv =====
// ----------------------------------------------------------------------------
// tps_div_stage
// one restoring division step per lane, quotient bits shift into quo
// ----------------------------------------------------------------------------
module tps_div_stage (
   input  logic              clock,
   input  logic              load,
   input  tps_pkg::div_type  div_d,
   output tps_pkg::div_type  div_ff
);
   import tps_pkg::*;

   logic [COORD_BITS:0] trial [LANES];
   logic [COORD_BITS:0] diff  [LANES];
   div_type             div_in;

   always_comb begin
      div_in = div_d;
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {div_d.lane[i].rem, div_d.lane[i].quo[COORD_BITS-1]};
         diff[i]  = trial[i] - {1'b0, div_d.lane[i].den};
         if (trial[i] >= {1'b0, div_d.lane[i].den}) begin
            div_in.lane[i].rem = diff[i][COORD_BITS-1:0];
            div_in.lane[i].quo = {div_d.lane[i].quo[COORD_BITS-2:0], 1'b1};
         end else begin
            div_in.lane[i].rem = trial[i][COORD_BITS-1:0];
            div_in.lane[i].quo = {div_d.lane[i].quo[COORD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         div_ff <= div_in;
      end
   end

endmodule

// ===== hw/rtl/triangle_plane_slice.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_slice: a triangle passes the input, setup, product and divider stages, then the output register
// throughput one triangle per cycle while the skid register is empty; the 32 one-bit divider stages set the depth
// a full output register plus skid register stalls the pipeline as one
// reset (synchronous, active high) clears all valid bits; payload is not reset
// ----------------------------------------------------------------------------
`include "triangle_plane_slice_assert.svh"

module triangle_plane_slice (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tps_pkg::coord_type req_ax,
   input  tps_pkg::coord_type req_ay,
   input  tps_pkg::coord_type req_az,
   input  tps_pkg::coord_type req_bx,
   input  tps_pkg::coord_type req_by,
   input  tps_pkg::coord_type req_bz,
   input  tps_pkg::coord_type req_cx,
   input  tps_pkg::coord_type req_cy,
   input  tps_pkg::coord_type req_cz,
   input  tps_pkg::coord_type req_plane_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output tps_pkg::coord_type rsp_seg_x1,
   output tps_pkg::coord_type rsp_seg_y1,
   output tps_pkg::coord_type rsp_seg_x2,
   output tps_pkg::coord_type rsp_seg_y2
);
   import tps_pkg::*;

   // pipeline occupancy, one bit per stage
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic                   advance;

   facet_type facet_ff;
   setup_type setup_q;
   div_type   div_q [DIV_STAGES+1];

   // final offset add on the last divider stage
   coord_type seg [LANES];
   logic      incoming;

   // output register and skid register
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_hit_ff;
   coord_type out_seg_ff [LANES];
   logic      skid_valid_ff;
   logic      skid_valid_in;
   logic      skid_hit_ff;
   coord_type skid_seg_ff [LANES];

   // the whole pipeline moves together; it only halts when the skid holds a result
   assign advance   = !skid_valid_ff;
   assign req_ready = advance;
   assign incoming  = advance && valid_ff[PIPE_STAGES-1];

   always_comb begin
      valid_in = {valid_ff[PIPE_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: input register
   always_ff @(posedge clock) begin
      if (advance) begin
         facet_ff.a.x <= req_ax;
         facet_ff.a.y <= req_ay;
         facet_ff.a.z <= req_az;
         facet_ff.b.x <= req_bx;
         facet_ff.b.y <= req_by;
         facet_ff.b.z <= req_bz;
         facet_ff.c.x <= req_cx;
         facet_ff.c.y <= req_cy;
         facet_ff.c.z <= req_cz;
         facet_ff.h   <= req_plane_z;
      end
   end

   // stage 1: straddle test and operand setup
   tps_setup u_setup (
      .clock    (clock),
      .load     (advance),
      .facet_d  (facet_ff),
      .setup_ff (setup_q)
   );

   // stage 2: span times height offset
   tps_mul u_mul (
      .clock   (clock),
      .load    (advance),
      .setup_d (setup_q),
      .div_ff  (div_q[0])
   );

   // stages 3 and up: one quotient bit each
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      tps_div_stage u_div (
         .clock  (clock),
         .load   (advance),
         .div_d  (div_q[g]),
         .div_ff (div_q[g+1])
      );
   end

   // apply the edge direction; the offset never leaves the edge span
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (div_q[DIV_STAGES].lane[i].neg) begin
            seg[i] = div_q[DIV_STAGES].lane[i].base -
                     coord_type'(div_q[DIV_STAGES].lane[i].quo);
         end else begin
            seg[i] = div_q[DIV_STAGES].lane[i].base +
                     coord_type'(div_q[DIV_STAGES].lane[i].quo);
         end
      end
   end

   // output side: a transfer frees the output register, the skid refills it first
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         out_valid_in  = skid_valid_ff || incoming;
         skid_valid_in = 1'b0;
      end else if (incoming) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_hit_ff <= skid_hit_ff;
            out_seg_ff <= skid_seg_ff;
         end else begin
            out_hit_ff <= div_q[DIV_STAGES].hit;
            out_seg_ff <= seg;
         end
      end else if (incoming) begin
         skid_hit_ff <= div_q[DIV_STAGES].hit;
         skid_seg_ff <= seg;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_hit    = out_hit_ff;
   assign rsp_seg_x1 = out_seg_ff[LANE_X1];
   assign rsp_seg_y1 = out_seg_ff[LANE_Y1];
   assign rsp_seg_x2 = out_seg_ff[LANE_X2];
   assign rsp_seg_y2 = out_seg_ff[LANE_Y2];

   // checks

   `TPS_ASSERT_NOW(a_no_hit_zero, rsp_valid && !rsp_hit,
      (rsp_seg_x1 == '0) && (rsp_seg_y1 == '0) && (rsp_seg_x2 == '0) && (rsp_seg_y2 == '0),
      "segment not zero without a hit")
   `TPS_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready,
      "input stalled while output register is empty")
   `TPS_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff,
      "skid register full while output register empty")
   `TPS_ASSERT_NEXT(a_enter_stage0, req_valid && req_ready, valid_ff[0],
      "accepted triangle missing from the input stage")
   `TPS_ASSERT_NOW(a_conserve, !$past(reset),
      ($countones(valid_ff) + $countones(out_valid_ff) + $countones(skid_valid_ff)) ==
      ($past($countones(valid_ff) + $countones(out_valid_ff) + $countones(skid_valid_ff))
       + $past($countones(req_valid && req_ready))
       - $past($countones(rsp_valid && rsp_ready))),
      "item count in flight does not match transfers")

endmodule
